@@ hw/rtl/fdbr_pkg.sv @@
package fdbr_pkg;

    localparam int POS_W        = 14;
    localparam int PIX_W        = 24;
    localparam int CNT_W        = 25;
    localparam int COORD_W      = 12;
    localparam int SIZE_W       = 13;
    localparam int TOTAL_W      = 5;
    localparam int DIM_W        = 13;
    localparam int MAXR_W       = 5;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int EVQ_DEPTH    = 4;
    localparam int EVQ_PTR_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RECT_CAP     = 2'd2;

    // one finished row, handed from the pixel side to the band side
    typedef struct packed {
        logic             has;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] right;
        logic [POS_W-1:0] row;
        logic             last_row;
        logic [CNT_W-1:0] count;
    } t_row_evt;

    typedef enum logic [1:0] {
        ST_BAND = 2'b01,
        ST_SUM  = 2'b10
    } t_back_st;

endpackage

@@ hw/rtl/fdbr_ifs.sv @@
interface fdbr_pix_if;
    logic                       valid;
    logic                       ready;
    logic [fdbr_pkg::PIX_W-1:0] old_pixel;
    logic [fdbr_pkg::PIX_W-1:0] new_pixel;

    modport source (output valid, output old_pixel, output new_pixel, input ready);
    modport sink   (input valid, input old_pixel, input new_pixel, output ready);
endinterface

interface fdbr_res_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [fdbr_pkg::COORD_W-1:0] rect_x;
    logic [fdbr_pkg::COORD_W-1:0] rect_y;
    logic [fdbr_pkg::SIZE_W-1:0]  rect_w;
    logic [fdbr_pkg::SIZE_W-1:0]  rect_h;
    logic [fdbr_pkg::TOTAL_W-1:0] rect_total;
    logic [fdbr_pkg::CNT_W-1:0]   dirty_count;
    logic                         overflowed;
    logic                         last;

    modport source (output valid, output kind, output rect_x, output rect_y, output rect_w,
                    output rect_h, output rect_total, output dirty_count,
                    output overflowed, output last, input ready);
    modport sink   (input valid, input kind, input rect_x, input rect_y, input rect_w,
                    input rect_h, input rect_total, input dirty_count,
                    input overflowed, input last, output ready);
endinterface

@@ hw/rtl/fdbr_evq.sv @@
module fdbr_evq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fdbr_pkg::t_row_evt i_evt,
    output logic               o_full,
    input  logic               i_pop,
    output fdbr_pkg::t_row_evt o_evt,
    output logic               o_empty
);

    fdbr_pkg::t_row_evt                 r_mem [fdbr_pkg::EVQ_DEPTH];
    logic [fdbr_pkg::EVQ_PTR_W-1:0]     r_wr_ptr;
    logic [fdbr_pkg::EVQ_PTR_W-1:0]     r_rd_ptr;
    logic [fdbr_pkg::EVQ_PTR_W:0]       r_count;
    logic [fdbr_pkg::EVQ_PTR_W:0]       n_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_count == (fdbr_pkg::EVQ_PTR_W + 1)'(fdbr_pkg::EVQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

endmodule

@@ hw/rtl/fdbr_front.sv @@
module fdbr_front #(
    parameter int CW = 12,
    parameter int RW = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fdbr_pix_if.sink           i_pix,
    input  logic [CW-1:0]      i_wm1,
    input  logic [RW-1:0]      i_hm1,
    input  logic               i_full,
    output logic               o_push,
    output fdbr_pkg::t_row_evt o_evt
);

    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;
    logic                       r_has;
    logic [CW-1:0]              r_left;
    logic [CW-1:0]              r_right;
    logic [fdbr_pkg::CNT_W-1:0] r_count;

    logic                       diff;
    logic                       row_end;
    logic                       last_row;
    logic                       accept;
    logic                       n_has;
    logic [CW-1:0]              n_left;
    logic [CW-1:0]              n_right;
    logic [fdbr_pkg::CNT_W-1:0] n_count;

    assign diff     = (i_pix.old_pixel != i_pix.new_pixel);
    assign row_end  = (r_col >= i_wm1);
    assign last_row = (r_row >= i_hm1);
    assign i_pix.ready = !(i_full && row_end);
    assign accept   = i_pix.valid && i_pix.ready;
    assign o_push   = accept && row_end;

    assign n_has   = r_has || diff;
    assign n_left  = (diff && !r_has) ? r_col : r_left;
    assign n_right = diff ? r_col : r_right;
    assign n_count = (diff && (r_count != fdbr_pkg::COUNT_MAX)) ? r_count + 1'b1 : r_count;

    always_comb begin
        o_evt.has      = n_has;
        o_evt.left     = fdbr_pkg::POS_W'(n_left);
        o_evt.right    = fdbr_pkg::POS_W'(n_right);
        o_evt.row      = fdbr_pkg::POS_W'(r_row);
        o_evt.last_row = last_row;
        o_evt.count    = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_has   <= 1'b0;
            r_left  <= '0;
            r_right <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col   <= '0;
                r_has   <= 1'b0;
                r_left  <= '0;
                r_right <= '0;
                if (last_row) begin
                    r_row   <= '0;
                    r_count <= '0;
                end else begin
                    r_row   <= r_row + 1'b1;
                    r_count <= n_count;
                end
            end else begin
                r_col   <= r_col + 1'b1;
                r_has   <= n_has;
                r_left  <= n_left;
                r_right <= n_right;
                r_count <= n_count;
            end
        end
    end

endmodule

@@ hw/rtl/fdbr_back.sv @@
module fdbr_back #(
    parameter int RLW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdbr_pkg::t_row_evt i_evt,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic [RLW-1:0]     i_limit,
    fdbr_res_if.source         o_res
);

    localparam int PW = fdbr_pkg::POS_W;

    fdbr_pkg::t_back_st           r_st;
    logic                         r_open;
    logic [PW-1:0]                r_top;
    logic [PW-1:0]                r_left;
    logic [PW-1:0]                r_right;
    logic [RLW-1:0]               r_rects;
    logic                         r_ovf;

    logic                         r_valid;
    logic                         r_kind;
    logic [fdbr_pkg::COORD_W-1:0] r_x;
    logic [fdbr_pkg::COORD_W-1:0] r_y;
    logic [fdbr_pkg::SIZE_W-1:0]  r_w;
    logic [fdbr_pkg::SIZE_W-1:0]  r_h;
    logic [fdbr_pkg::TOTAL_W-1:0] r_total;
    logic [fdbr_pkg::CNT_W-1:0]   r_dirty;
    logic                         r_oflag;
    logic                         r_last;

    logic                         out_free;
    logic                         open_after;
    logic [PW-1:0]                top_after;
    logic [PW-1:0]                left_after;
    logic [PW-1:0]                right_after;
    logic                         close;
    logic [PW-1:0]                end_y;
    logic                         under;
    logic                         emit_rect;
    logic                         band_go;
    logic                         sum_go;
    logic [PW:0]                  span_w;
    logic [PW:0]                  span_h;

    assign out_free    = !r_valid || o_res.ready;
    assign open_after  = r_open || i_evt.has;
    assign top_after   = (!r_open && i_evt.has) ? i_evt.row : r_top;
    assign left_after  = (i_evt.has && (!r_open || (i_evt.left < r_left)))
                         ? i_evt.left : r_left;
    assign right_after = (i_evt.has && (!r_open || (i_evt.right > r_right)))
                         ? i_evt.right : r_right;
    assign close       = open_after && (!i_evt.has || i_evt.last_row);
    assign end_y       = i_evt.has ? i_evt.row : i_evt.row - 1'b1;
    assign under       = (r_rects < i_limit);
    assign emit_rect   = close && under;
    assign span_w      = {1'b0, right_after} - {1'b0, left_after} + 1'b1;
    assign span_h      = {1'b0, end_y} - {1'b0, top_after} + 1'b1;

    always_comb begin
        band_go = 1'b0;
        sum_go  = 1'b0;
        unique case (r_st)
            fdbr_pkg::ST_BAND: begin
                band_go = !i_empty && (!emit_rect || out_free);
            end
            fdbr_pkg::ST_SUM: begin
                sum_go = !i_empty && out_free;
            end
            default: begin
                band_go = 1'b0;
                sum_go  = 1'b0;
            end
        endcase
    end

    assign o_pop = (band_go && !i_evt.last_row) || sum_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= fdbr_pkg::ST_BAND;
            r_open  <= 1'b0;
            r_top   <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_rects <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (band_go) begin
                r_open  <= open_after && !close;
                r_top   <= top_after;
                r_left  <= left_after;
                r_right <= right_after;
                if (close) begin
                    if (under) begin
                        r_rects <= r_rects + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                if (i_evt.last_row) begin
                    r_st <= fdbr_pkg::ST_SUM;
                end
            end
            if (sum_go) begin
                r_open  <= 1'b0;
                r_rects <= '0;
                r_ovf   <= 1'b0;
                r_st    <= fdbr_pkg::ST_BAND;
            end
            if ((band_go && emit_rect) || sum_go) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (band_go && emit_rect) begin
            r_kind  <= fdbr_pkg::KIND_RECT;
            r_x     <= fdbr_pkg::COORD_W'(left_after);
            r_y     <= fdbr_pkg::COORD_W'(top_after);
            r_w     <= fdbr_pkg::SIZE_W'(span_w);
            r_h     <= fdbr_pkg::SIZE_W'(span_h);
            r_total <= '0;
            r_dirty <= '0;
            r_oflag <= 1'b0;
            r_last  <= 1'b0;
        end else if (sum_go) begin
            r_kind  <= fdbr_pkg::KIND_SUM;
            r_x     <= '0;
            r_y     <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_total <= fdbr_pkg::TOTAL_W'(r_rects);
            r_dirty <= i_evt.count;
            r_oflag <= r_ovf;
            r_last  <= 1'b1;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_kind;
    assign o_res.rect_x       = r_x;
    assign o_res.rect_y       = r_y;
    assign o_res.rect_w       = r_w;
    assign o_res.rect_h       = r_h;
    assign o_res.rect_total   = r_total;
    assign o_res.dirty_count  = r_dirty;
    assign o_res.overflowed   = r_oflag;
    assign o_res.last         = r_last;

endmodule

@@ hw/rtl/frame_dirty_band_rects_core.sv @@
// channel   dir  handshake       payload
// i_pix     in   valid/ready     old_pixel, new_pixel
// o_res     out  valid/ready     kind, rect_x/y/w/h, rect_total, dirty_count, overflowed, last
// apb       in   psel/penable    frame_width @0x0, frame_height @0x4, rect_cap @0x8
//
// one pixel request per cycle; the front side stalls only at a row end when the
// four-entry row queue is full
// the band side handles each row in its band state and a frame's last row in the band state, then
// in the summary state, so frames one pixel wide and high fill the row queue and stall the front side
// results leave through a single output register, one per cycle while o_res.ready is high
// synchronous active-low reset clears all control state; no clearing pass
module frame_dirty_band_rects_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int RECT_LIMIT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fdbr_pix_if.sink                        i_pix,
    fdbr_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdbr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fdbr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fdbr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RLW = $clog2(RECT_LIMIT + 1);

    logic [fdbr_pkg::DIM_W-1:0]  r_frame_width;
    logic [fdbr_pkg::DIM_W-1:0]  r_frame_height;
    logic [fdbr_pkg::MAXR_W-1:0] r_rect_cap;

    logic [1:0]               reg_idx;
    logic                     wr_en;
    logic [CW-1:0]            wm1;
    logic [RW-1:0]            hm1;
    logic [RLW-1:0]           limit;
    logic                     q_push;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_empty;
    fdbr_pkg::t_row_evt       q_in;
    fdbr_pkg::t_row_evt       q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fdbr_pkg::DIM_W'(1);
            r_frame_height <= fdbr_pkg::DIM_W'(1);
            r_rect_cap     <= fdbr_pkg::MAXR_W'(16);
        end else if (wr_en) begin
            unique case (reg_idx)
                fdbr_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[fdbr_pkg::DIM_W-1:0];
                fdbr_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[fdbr_pkg::DIM_W-1:0];
                fdbr_pkg::REG_RECT_CAP:     r_rect_cap     <= pwdata[fdbr_pkg::MAXR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fdbr_pkg::REG_FRAME_WIDTH:  prdata = fdbr_pkg::APB_DATA_W'(r_frame_width);
            fdbr_pkg::REG_FRAME_HEIGHT: prdata = fdbr_pkg::APB_DATA_W'(r_frame_height);
            fdbr_pkg::REG_RECT_CAP:     prdata = fdbr_pkg::APB_DATA_W'(r_rect_cap);
            default:                    prdata = '0;
        endcase
    end

    // a zero width or height acts as one; oversize values, rect cap included, are capped
    always_comb begin
        if (r_frame_width == '0) begin
            wm1 = '0;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(r_frame_width - 1'b1);
        end
        if (r_frame_height == '0) begin
            hm1 = '0;
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = RW'(r_frame_height - 1'b1);
        end
        if (32'(r_rect_cap) > RECT_LIMIT) begin
            limit = RLW'(RECT_LIMIT);
        end else begin
            limit = RLW'(r_rect_cap);
        end
    end

    fdbr_front #(
        .CW (CW),
        .RW (RW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_wm1   (wm1),
        .i_hm1   (hm1),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_evt   (q_in)
    );

    fdbr_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_evt   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_evt   (q_out),
        .o_empty (q_empty)
    );

    fdbr_back #(
        .RLW (RLW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_limit (limit),
        .o_res   (o_res)
    );

endmodule
